// File: design/pbrc_pkg.sv
package pbrc_pkg;

  localparam int KEEP_LENGTH   = 12;
  localparam int PARCEL_DIGITS = 11;
  localparam int DIGITS_W      = PARCEL_DIGITS * 4;

  localparam logic [7:0] CHAR_NUL   = 8'd0;
  localparam logic [7:0] CHAR_CR    = 8'd13;
  localparam logic [7:0] CHAR_SPACE = 8'd32;

  // record_status codes
  localparam logic [2:0] STAT_OK        = 3'd0;
  localparam logic [2:0] STAT_MISMATCH  = 3'd1;
  localparam logic [2:0] STAT_TOO_LONG  = 3'd2;
  localparam logic [2:0] STAT_TOO_SHORT = 3'd3;
  localparam logic [2:0] STAT_UNCHECKED = 3'd4;

  // configuration register indexes
  localparam logic [2:0] REG_MAX_LINE_LENGTH = 3'd0;
  localparam logic [2:0] REG_CHECK_DIGIT     = 3'd1;
  localparam logic [2:0] REG_ODD_WEIGHT      = 3'd2;
  localparam logic [2:0] REG_SUM_INCREMENT   = 3'd3;
  localparam logic [2:0] REG_CHECK_MODULUS   = 3'd4;

  // what the top level knows about a closed record
  typedef struct packed {
    logic len_ok;
    logic too_long;
    logic chk;
  } rec_info_t;

  // buffer read request from the sequencer
  typedef struct packed {
    logic       rd_en;
    logic [3:0] pos;
  } mem_req_t;

  typedef struct packed {
    logic busy;
    logic done;
  } seq_status_t;

  typedef struct packed {
    logic [2:0]          status;
    logic [DIGITS_W-1:0] digits;
    logic [3:0]          computed;
    logic [3:0]          received;
  } result_t;

endpackage

// File: design/pbrc_seq.sv
module pbrc_seq import pbrc_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        go,
  input  rec_info_t   info,
  input  logic        out_free,
  input  logic [7:0]  rd_data,
  input  logic [3:0]  odd_weight,
  input  logic [3:0]  sum_increment,
  input  logic [3:0]  check_modulus,
  output mem_req_t    mem,
  output seq_status_t stat,
  output result_t     res
);

  typedef enum logic [2:0] {
    OP_NONE  = 3'd0,
    OP_DIGIT = 3'd1,
    OP_RECV  = 3'd2,
    OP_INC   = 3'd3,
    OP_DIV   = 3'd4,
    OP_CHECK = 3'd5,
    OP_DONE  = 3'd6
  } op_t;

  typedef enum logic [1:0] {
    JC_NONE      = 2'd0,
    JC_LEN_BAD   = 2'd1,
    JC_UNCHECKED = 2'd2,
    JC_ALWAYS    = 2'd3
  } jc_t;

  typedef struct packed {
    logic       rd_en;
    logic [3:0] pos;
    op_t        op;
    logic       w_odd;
    logic [3:0] k;
    jc_t        jc;
    logic [4:0] target;
  } ucw_t;

  localparam logic [4:0] UC_FIRST_DIGIT = 5'd1;
  localparam logic [4:0] UC_LAST_DIGIT  = 5'd11;
  localparam logic [4:0] UC_MODE        = 5'd12;
  localparam logic [4:0] UC_RECV        = 5'd13;
  localparam logic [4:0] UC_INC         = 5'd14;
  localparam logic [4:0] UC_DIV_FIRST   = 5'd15;
  localparam logic [4:0] UC_DIV_LAST    = 5'd24;
  localparam logic [4:0] UC_CHECK       = 5'd25;
  localparam logic [4:0] UC_FIN         = 5'd26;

  // Microprogram. Data read in one step is used in the next.
  function automatic ucw_t ucode(input logic [4:0] step);
    ucw_t       w;
    logic [4:0] kk;
    w        = '0;
    w.op     = OP_NONE;
    w.jc     = JC_NONE;
    w.target = UC_FIN;
    kk       = UC_DIV_LAST - step;
    if (step == 5'd0) begin
      w.rd_en = 1'b1;
      w.jc    = JC_LEN_BAD;
    end else if (step >= UC_FIRST_DIGIT && step <= UC_LAST_DIGIT) begin
      // read the next character, fold in the previous one
      w.rd_en = 1'b1;
      w.pos   = step[3:0];
      w.op    = OP_DIGIT;
      w.w_odd = step[0];
    end else if (step == UC_MODE) begin
      w.jc = JC_UNCHECKED;
    end else if (step == UC_RECV) begin
      w.op = OP_RECV;
    end else if (step == UC_INC) begin
      w.op = OP_INC;
    end else if (step >= UC_DIV_FIRST && step <= UC_DIV_LAST) begin
      w.op = OP_DIV;
      w.k  = kk[3:0];
    end else if (step == UC_CHECK) begin
      w.op = OP_CHECK;
    end else if (step == UC_FIN) begin
      w.op = OP_DONE;
    end else begin
      w.jc = JC_ALWAYS;
    end
    return w;
  endfunction

  logic                busy;
  logic [4:0]          pc;
  logic [9:0]          acc;
  logic [DIGITS_W-1:0] digits;
  logic [3:0]          comp;
  logic [3:0]          recv;

  ucw_t       uw;
  logic [3:0] dval;
  logic [3:0] weight;
  logic [7:0] prod;
  logic [3:0] modv;
  logic [13:0] dsh;
  logic [4:0] chk_raw;
  logic [3:0] chk_val;
  logic       taken;

  assign uw     = ucode(pc);
  assign dval   = (rd_data >= 8'd48 && rd_data <= 8'd57) ? 4'(rd_data - 8'd48) : 4'd0;
  assign weight = uw.w_odd ? odd_weight : 4'd1;
  assign prod   = 8'(dval) * 8'(weight);
  assign modv   = (check_modulus == 4'd0) ? 4'd1 : check_modulus;
  assign dsh    = 14'(modv) << uw.k;
  assign chk_raw = 5'd20 - {1'b0, acc[3:0]};

  always_comb begin
    if (chk_raw >= 5'd20) begin
      chk_val = 4'(chk_raw - 5'd20);
    end else if (chk_raw >= 5'd10) begin
      chk_val = 4'(chk_raw - 5'd10);
    end else begin
      chk_val = chk_raw[3:0];
    end
  end

  always_comb begin
    unique case (uw.jc)
      JC_NONE:      taken = 1'b0;
      JC_LEN_BAD:   taken = !info.len_ok;
      JC_UNCHECKED: taken = !info.chk;
      JC_ALWAYS:    taken = 1'b1;
      default:      taken = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      pc   <= '0;
    end else if (go) begin
      busy <= 1'b1;
      pc   <= '0;
    end else if (busy) begin
      if (uw.op == OP_DONE) begin
        // hold at the final step until the output register is free
        if (out_free) begin
          busy <= 1'b0;
        end
      end else if (taken) begin
        pc <= uw.target;
      end else begin
        pc <= pc + 5'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      acc    <= '0;
      digits <= '0;
      comp   <= '0;
      recv   <= '0;
    end else if (busy) begin
      unique case (uw.op)
        OP_DIGIT: begin
          digits <= {digits[DIGITS_W-5:0], dval};
          acc    <= acc + 10'(prod);
        end
        OP_RECV:  recv <= dval;
        OP_INC:   acc <= acc + 10'(sum_increment);
        OP_DIV: begin
          if (14'(acc) >= dsh) begin
            acc <= acc - dsh[9:0];
          end
        end
        OP_CHECK: comp <= chk_val;
        OP_NONE, OP_DONE: ;
        default: ;
      endcase
    end
  end

  always_comb begin
    if (info.len_ok) begin
      if (info.chk) begin
        res.status = (comp == recv) ? STAT_OK : STAT_MISMATCH;
      end else begin
        res.status = STAT_UNCHECKED;
      end
    end else if (info.too_long) begin
      res.status = STAT_TOO_LONG;
    end else begin
      res.status = STAT_TOO_SHORT;
    end
  end

  assign res.digits   = digits;
  assign res.computed = comp;
  assign res.received = recv;

  assign mem.rd_en = busy && uw.rd_en;
  assign mem.pos   = uw.pos;

  assign stat.busy = busy;
  assign stat.done = busy && (uw.op == OP_DONE) && out_free;

endmodule

// File: design/parcel_barcode_record_checker_top.sv
// Parcel barcode line checker.
// Input channel: one received character per transfer on rx_byte (in_valid / in_stall).
// Every character but CR is stored (NUL as a space); once the line holds the configured
// maximum (clamped to 12..depth), the next character first trims it to its last twelve.
// A CR closes the record and gives exactly one result on the output channel
// (out_valid / out_stall): length status, eleven digits and the check digits.
// Non-CR characters can follow back to back while in_stall is low.
// After a CR the microprogram runs from a 27-step control store: a checked record of
// right length runs every step, an unchecked one jumps from the mode step to the last
// step, and one of wrong length jumps there from the first. The program walks the
// eleven digits through the line buffer (one read port), then ten remainder steps.
// in_stall is high while the program runs and falls at the edge that raises out_valid.
// A finished result sits in the output register; while out_stall holds it, the next
// record's program waits at its last step and new characters are not taken meanwhile.
// Configuration: cfg_we / cfg_index / cfg_data. The user must write them only while
// idle; the block does not enforce it. Reset (rst, synchronous) empties the line, drops
// any result and restores the register defaults: 64, 1, 3, 1, 10.
module parcel_barcode_record_checker_top import pbrc_pkg::*; #(
  parameter int BUFFER_DEPTH = 64
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [7:0]          rx_byte,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [2:0]          record_status,
  output logic [6:0]          record_length,
  output logic [DIGITS_W-1:0] parcel_digits,
  output logic [3:0]          computed_check,
  output logic [3:0]          received_check,
  input  logic                cfg_we,
  input  logic [2:0]          cfg_index,
  input  logic [6:0]          cfg_data
);

  localparam int AW = $clog2(BUFFER_DEPTH);
  localparam int CW = $clog2(BUFFER_DEPTH + 1);
  localparam int LW = (CW > 7) ? CW : 7;
  localparam int SW = CW + 1;

  logic [6:0] max_line_length;
  logic       check_digit_included;
  logic [3:0] odd_weight;
  logic [3:0] sum_increment;
  logic [3:0] check_modulus;

  logic [7:0]    line_buffer [BUFFER_DEPTH];
  logic [7:0]    rd_q;
  logic [CW-1:0] line_count;
  logic [AW-1:0] line_start;
  logic [CW-1:0] rec_count;
  logic [AW-1:0] rec_start;
  rec_info_t     rec_info;

  mem_req_t    mem;
  seq_status_t stat;
  result_t     res;
  logic        go;
  logic        in_fire;
  logic        out_free;
  logic        is_cr;

  logic [LW-1:0] lim;
  logic          trim;
  logic [SW-1:0] trim_sum;
  logic [SW-1:0] trim_wrap;
  logic [AW-1:0] eff_start;
  logic [CW-1:0] eff_count;
  logic [SW-1:0] wr_sum;
  logic [SW-1:0] wr_wrap;
  logic [AW-1:0] wr_addr;
  logic [SW-1:0] rd_sum;
  logic [SW-1:0] rd_wrap;
  logic [AW-1:0] rd_addr;
  logic [7:0]    wr_data;
  logic [CW-1:0] valid_len;

  assign in_stall = stat.busy;
  assign in_fire  = in_valid && !in_stall;
  assign is_cr    = (rx_byte == CHAR_CR);
  assign go       = in_fire && is_cr;
  assign out_free = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_line_length      <= 7'd64;
      check_digit_included <= 1'b1;
      odd_weight           <= 4'd3;
      sum_increment        <= 4'd1;
      check_modulus        <= 4'd10;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_MAX_LINE_LENGTH: max_line_length      <= cfg_data;
        REG_CHECK_DIGIT:     check_digit_included <= cfg_data[0];
        REG_ODD_WEIGHT:      odd_weight           <= cfg_data[3:0];
        REG_SUM_INCREMENT:   sum_increment        <= cfg_data[3:0];
        REG_CHECK_MODULUS:   check_modulus        <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

  // fill limit clamped to the kept length and the buffer depth
  always_comb begin
    if (LW'(max_line_length) < LW'(KEEP_LENGTH)) begin
      lim = LW'(KEEP_LENGTH);
    end else if (LW'(max_line_length) > LW'(BUFFER_DEPTH)) begin
      lim = LW'(BUFFER_DEPTH);
    end else begin
      lim = LW'(max_line_length);
    end
  end

  assign trim      = LW'(line_count) >= lim;
  assign trim_sum  = SW'(line_start) + SW'(line_count) - SW'(KEEP_LENGTH);
  assign trim_wrap = (trim_sum >= SW'(BUFFER_DEPTH)) ? trim_sum - SW'(BUFFER_DEPTH) : trim_sum;
  assign eff_start = trim ? trim_wrap[AW-1:0] : line_start;
  assign eff_count = trim ? CW'(KEEP_LENGTH) : line_count;

  assign wr_sum  = SW'(eff_start) + SW'(eff_count);
  assign wr_wrap = (wr_sum >= SW'(BUFFER_DEPTH)) ? wr_sum - SW'(BUFFER_DEPTH) : wr_sum;
  assign wr_addr = wr_wrap[AW-1:0];
  assign wr_data = (rx_byte == CHAR_NUL) ? CHAR_SPACE : rx_byte;

  assign rd_sum  = SW'(rec_start) + SW'(mem.pos);
  assign rd_wrap = (rd_sum >= SW'(BUFFER_DEPTH)) ? rd_sum - SW'(BUFFER_DEPTH) : rd_sum;
  assign rd_addr = rd_wrap[AW-1:0];

  assign valid_len = check_digit_included ? CW'(PARCEL_DIGITS + 1) : CW'(PARCEL_DIGITS);

  always_ff @(posedge clk) begin
    if (in_fire && !is_cr) begin
      line_buffer[wr_addr] <= wr_data;
    end
    if (mem.rd_en) begin
      rd_q <= line_buffer[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      line_count <= '0;
      line_start <= '0;
    end else if (in_fire) begin
      if (is_cr) begin
        line_count <= '0;
        line_start <= '0;
      end else begin
        line_count <= eff_count + CW'(1);
        line_start <= eff_start;
      end
    end
  end

  // snapshot of the closed record for the sequencer
  always_ff @(posedge clk) begin
    if (go) begin
      rec_start         <= eff_start;
      rec_count         <= eff_count;
      rec_info.chk      <= check_digit_included;
      rec_info.len_ok   <= (eff_count == valid_len);
      rec_info.too_long <= (eff_count > valid_len);
    end
  end

  pbrc_seq u_seq (
    .clk           (clk),
    .rst           (rst),
    .go            (go),
    .info          (rec_info),
    .out_free      (out_free),
    .rd_data       (rd_q),
    .odd_weight    (odd_weight),
    .sum_increment (sum_increment),
    .check_modulus (check_modulus),
    .mem           (mem),
    .stat          (stat),
    .res           (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (stat.done) begin
      out_valid <= 1'b1;
    end else if (out_valid && !out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (stat.done) begin
      record_status  <= res.status;
      record_length  <= 7'(rec_count);
      parcel_digits  <= res.digits;
      computed_check <= res.computed;
      received_check <= res.received;
    end
  end

endmodule

// File: design/pbrc_checker.sv
module pbrc_checker import pbrc_pkg::*; (
  input logic                clk,
  input logic                rst,
  input logic                out_valid,
  input logic                out_stall,
  input logic [2:0]          record_status,
  input logic [6:0]          record_length,
  input logic [DIGITS_W-1:0] parcel_digits,
  input logic [3:0]          computed_check,
  input logic [3:0]          received_check
);

  // a result that is not taken stays put
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(record_status) && $stable(parcel_digits))
    else $error("result changed while stalled");

  a_reset_clear: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result shown right after reset");

  a_bad_len_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && (record_status == STAT_TOO_LONG || record_status == STAT_TOO_SHORT)
      |-> parcel_digits == '0 && computed_check == 4'd0 && received_check == 4'd0)
    else $error("fields not cleared on wrong length");

  a_ok_match: assert property (@(posedge clk) disable iff (rst)
    out_valid && record_status == STAT_OK
      |-> computed_check == received_check && record_length == 7'(PARCEL_DIGITS + 1))
    else $error("check passed without match or with wrong length");

  a_unchecked: assert property (@(posedge clk) disable iff (rst)
    out_valid && record_status == STAT_UNCHECKED
      |-> computed_check == 4'd0 && received_check == 4'd0
          && record_length == 7'(PARCEL_DIGITS))
    else $error("unchecked record with check fields or wrong length");

endmodule

bind parcel_barcode_record_checker_top pbrc_checker u_pbrc_checker (.*);

// File: dv/parcel_barcode_record_checker_top_test.sv
`timescale 1ns / 100ps

module parcel_barcode_record_checker_top_test;
  import pbrc_pkg::*;

  localparam int LINE_DEPTH     = 64;
  localparam int SETTLE_CYCLES  = 40;
  localparam int LONG_HOLD      = 300;
  localparam int WATCHDOG_LIMIT = 2000;

  typedef logic [7:0] byte_q_t[$];

  typedef struct packed {
    logic [2:0]          status;
    logic [6:0]          length;
    logic [DIGITS_W-1:0] digits;
    logic [3:0]          computed;
    logic [3:0]          received;
  } parcel_record_t;

  // Mirrors the line buffer and the registers; turns each transfer into the record it closes.
  class parcel_line_tracker;
    logic [7:0]     line_mem [LINE_DEPTH];
    int unsigned    line_count;
    int unsigned    line_start;
    logic [6:0]     max_len;
    logic           chk_on;
    logic [3:0]     odd_w;
    logic [3:0]     sum_inc;
    logic [3:0]     modulus;
    parcel_record_t pending_records[$];
    int             bad_records;

    function new();
      line_count  = 0;
      line_start  = 0;
      max_len     = 7'd64;
      chk_on      = 1'b1;
      odd_w       = 4'd3;
      sum_inc     = 4'd1;
      modulus     = 4'd10;
      bad_records = 0;
    endfunction

    function void set_register(logic [2:0] idx, logic [6:0] data);
      case (idx)
        REG_MAX_LINE_LENGTH: max_len = data;
        REG_CHECK_DIGIT:     chk_on  = data[0];
        REG_ODD_WEIGHT:      odd_w   = data[3:0];
        REG_SUM_INCREMENT:   sum_inc = data[3:0];
        REG_CHECK_MODULUS:   modulus = data[3:0];
        default: ;
      endcase
    endfunction

    function int unsigned pending();
      return pending_records.size();
    endfunction

    function logic [3:0] digit_of(logic [7:0] c);
      return (c >= 8'h30 && c <= 8'h39) ? 4'(c - 8'h30) : 4'd0;
    endfunction

    function logic [7:0] char_at(int unsigned pos);
      return line_mem[(line_start + pos) % LINE_DEPTH];
    endfunction

    // Rightmost data digit sits in the low nibble and takes the odd weight.
    function logic [3:0] weighted_check(logic [DIGITS_W-1:0] d);
      int unsigned total;
      int unsigned divisor;
      int unsigned rem;
      int          i;
      total = int'(sum_inc);
      for (i = 0; i < PARCEL_DIGITS; i++)
        total += int'(d[4*i +: 4]) * ((i % 2 == 0) ? int'(odd_w) : 1);
      divisor = (modulus == 4'd0) ? 1 : int'(modulus);
      rem     = total % divisor;
      return 4'((20 - rem) % 10);
    endfunction

    function void take_char(logic [7:0] b);
      parcel_record_t rec;
      int unsigned    limit;
      int unsigned    want;
      int             i;
      limit = (max_len < KEEP_LENGTH) ? KEEP_LENGTH : int'(max_len);
      if (limit > LINE_DEPTH) limit = LINE_DEPTH;
      // trim to the last twelve before the character is handled
      if (line_count >= limit) begin
        line_start = (line_start + line_count - KEEP_LENGTH) % LINE_DEPTH;
        line_count = KEEP_LENGTH;
      end
      if (b != CHAR_CR) begin
        line_mem[(line_start + line_count) % LINE_DEPTH] = (b == CHAR_NUL) ? CHAR_SPACE : b;
        line_count++;
        return;
      end
      want       = chk_on ? PARCEL_DIGITS + 1 : PARCEL_DIGITS;
      rec        = '0;
      rec.length = 7'(line_count);
      if (line_count == want) begin
        for (i = 0; i < PARCEL_DIGITS; i++)
          rec.digits = {rec.digits[DIGITS_W-5:0], digit_of(char_at(i))};
        if (chk_on) begin
          rec.computed = weighted_check(rec.digits);
          rec.received = digit_of(char_at(PARCEL_DIGITS));
          rec.status   = (rec.computed == rec.received) ? STAT_OK : STAT_MISMATCH;
        end else begin
          rec.status = STAT_UNCHECKED;
        end
      end else if (line_count > want) begin
        rec.status = STAT_TOO_LONG;
      end else begin
        rec.status = STAT_TOO_SHORT;
      end
      pending_records.push_back(rec);
      line_count = 0;
      line_start = 0;
    endfunction

    function void match_record(parcel_record_t got);
      parcel_record_t want;
      if (pending_records.size() == 0) begin
        bad_records++;
        if (bad_records <= 10)
          $display("unexpected record: status %0d length %0d digits %h check %0d/%0d",
                   got.status, got.length, got.digits, got.computed, got.received);
        return;
      end
      want = pending_records.pop_front();
      if (got.status !== want.status || got.length !== want.length ||
          got.digits !== want.digits || got.computed !== want.computed ||
          got.received !== want.received) begin
        bad_records++;
        if (bad_records <= 10) begin
          $display("record differs: expected status %0d length %0d digits %h check %0d/%0d",
                   want.status, want.length, want.digits, want.computed, want.received);
          $display("                got      status %0d length %0d digits %h check %0d/%0d",
                   got.status, got.length, got.digits, got.computed, got.received);
        end
      end
    endfunction
  endclass

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                in_valid = 1'b0;
  logic                in_stall;
  logic [7:0]          rx_byte = 8'd0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  logic [2:0]          record_status;
  logic [6:0]          record_length;
  logic [DIGITS_W-1:0] parcel_digits;
  logic [3:0]          computed_check;
  logic [3:0]          received_check;
  logic                cfg_we = 1'b0;
  logic [2:0]          cfg_index = 3'd0;
  logic [6:0]          cfg_data = 7'd0;

  bit idle_on = 1'b1;
  bit hold_request = 1'b0;

  parcel_line_tracker tracker = new();

  parcel_barcode_record_checker_top #(
    .BUFFER_DEPTH(LINE_DEPTH)
  ) uut (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .rx_byte        (rx_byte),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .record_status  (record_status),
    .record_length  (record_length),
    .parcel_digits  (parcel_digits),
    .computed_check (computed_check),
    .received_check (received_check),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic logic [7:0] any_char();
    logic [7:0] b;
    if ($urandom_range(0, 7) == 0) return CHAR_NUL;
    b = 8'($urandom_range(0, 255));
    return (b == CHAR_CR) ? CHAR_NUL : b;
  endfunction

  function automatic logic [7:0] digit_char();
    return 8'h30 + 8'($urandom_range(0, 9));
  endfunction

  // check character that the current settings expect for the first eleven characters
  function automatic logic [7:0] check_char(byte_q_t line);
    logic [DIGITS_W-1:0] d;
    int                  i;
    d = '0;
    for (i = 0; i < PARCEL_DIGITS; i++)
      d = {d[DIGITS_W-5:0], tracker.digit_of(line[i])};
    return 8'h30 + 8'(tracker.weighted_check(d));
  endfunction

  task automatic send_byte(input logic [7:0] b);
    if (idle_on && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    in_valid <= 1'b1;
    rx_byte  <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    tracker.take_char(b);
  endtask

  task automatic send_line(input byte_q_t line);
    foreach (line[i]) send_byte(line[i]);
    send_byte(CHAR_CR);
  endtask

  task automatic send_random_record(output int n_sent);
    byte_q_t    line;
    int         kind;
    int         len;
    int         i;
    logic [7:0] c;
    kind = $urandom_range(0, 99);
    if (kind < 70) begin
      for (i = 0; i < PARCEL_DIGITS; i++)
        line.push_back(($urandom_range(0, 15) == 0) ? any_char() : digit_char());
      if (tracker.chk_on) begin
        c = check_char(line);
        // spoil the check now and then
        if ($urandom_range(0, 4) == 0)
          c = 8'h30 + 8'((c - 8'h30 + $urandom_range(1, 9)) % 10);
        line.push_back(c);
      end
    end else begin
      if (kind < 85)      len = $urandom_range(0, 13);
      else if (kind < 95) len = $urandom_range(13, 30);
      else                len = $urandom_range(60, 80);
      for (i = 0; i < len; i++)
        line.push_back(($urandom_range(0, 2) == 0) ? any_char() : digit_char());
    end
    send_line(line);
    n_sent = line.size() + 1;
  endtask

  task automatic send_records(input int n_items);
    int sent;
    int k;
    sent = 0;
    while (sent < n_items) begin
      send_random_record(k);
      sent += k;
    end
  endtask

  task automatic wait_results_drained();
    in_valid <= 1'b0;
    while (tracker.pending() != 0) @(posedge clk);
  endtask

  task automatic write_register(input logic [2:0] idx, input logic [6:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    tracker.set_register(idx, data);
  endtask

  task automatic config_phase(input logic [6:0] max_len, input logic [6:0] chk,
                              input logic [6:0] odd_w, input logic [6:0] inc,
                              input logic [6:0] modulus);
    wait_results_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    write_register(REG_MAX_LINE_LENGTH, max_len);
    write_register(REG_CHECK_DIGIT, chk);
    write_register(REG_ODD_WEIGHT, odd_w);
    write_register(REG_SUM_INCREMENT, inc);
    write_register(REG_CHECK_MODULUS, modulus);
    // an index past the list must leave everything alone
    write_register(3'(REG_CHECK_MODULUS + 1 + $urandom_range(0, 2)),
                   7'($urandom_range(0, 127)));
    cfg_we <= 1'b0;
  endtask

  task automatic random_phase();
    config_phase(7'($urandom_range(0, 127)), 7'($urandom_range(0, 127)),
                 7'($urandom_range(0, 127)), 7'($urandom_range(0, 127)),
                 7'($urandom_range(0, 127)));
    send_records(100);
  endtask

  initial begin : receiver
    int   stall_left;
    int   hold_left;
    logic stall_next;
    stall_left = 0;
    hold_left  = 0;
    forever begin
      @(posedge clk);
      if (!rst && out_valid && !out_stall)
        tracker.match_record({record_status, record_length, parcel_digits,
                              computed_check, received_check});
      if (hold_request) begin
        hold_request = 1'b0;
        hold_left    = LONG_HOLD;
      end
      if (hold_left > 0) begin
        hold_left--;
        stall_next = 1'b1;
      end else if (stall_left > 0) begin
        stall_left--;
        stall_next = 1'b1;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(1, 6) - 1;
        stall_next = 1'b1;
      end else begin
        stall_next = 1'b0;
      end
      out_stall <= stall_next;
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet = 0;
      else quiet++;
    end
    $display("Mismatches found");
    $finish;
  end

  initial begin : stimulus
    byte_q_t line;
    int      i;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // register defaults: empty record, a clean checked record, then one
    // with NUL, 0xFF and characters either side of the digit range
    line = {};
    send_line(line);
    for (i = 0; i < PARCEL_DIGITS; i++) line.push_back(8'h39 - 8'(i % 10));
    line.push_back(check_char(line));
    send_line(line);
    line = '{CHAR_NUL, 8'hFF, 8'h30, 8'h39, 8'h2F, 8'h3A,
             8'h35, 8'h35, 8'h35, 8'h35, 8'h35};
    line.push_back(check_char(line));
    send_line(line);

    config_phase(7'd12, 7'd1, 7'd0, 7'd0, 7'd1);
    send_records(50);
    // hold the output long enough for the input to back up
    hold_request = 1'b1;
    send_records(60);

    config_phase(7'd64, 7'd0, 7'd15, 7'd15, 7'd15);
    send_records(50);
    wait_results_drained();
    send_records(50);

    config_phase(7'd0, 7'd1, 7'd15, 7'd15, 7'd0);
    send_records(100);

    config_phase(7'd127, 7'h7F, 7'd9, 7'd9, 7'd15);
    send_records(100);

    config_phase(7'd11, 7'd1, 7'd1, 7'd9, 7'd7);
    send_records(100);

    repeat (2) random_phase();

    idle_on = 1'b0;
    random_phase();

    wait_results_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (tracker.bad_records == 0 && tracker.pending() == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

endmodule

// File: parcel_barcode_record_checker_top.f
design/pbrc_pkg.sv
design/pbrc_seq.sv
design/parcel_barcode_record_checker_top.sv
design/pbrc_checker.sv
dv/parcel_barcode_record_checker_top_test.sv
